// ===== src/gnlh_pkg.sv =====
// Shared types and constants of the gated nearest lane heading block.
// Used by the controller, the datapath and the top level.
// No dependencies.
package gnlh_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 32;
    localparam int HEAD_W   = 16;
    localparam int WIDTH_W  = 16;
    localparam int GATE_W   = 33;
    localparam int ENTRY_W  = 2 * POS_W + HEAD_W + GATE_W;

    // |d| >= 2^ABS_KEEP squares past any gate
    localparam int ABS_W    = POS_W + 1;
    localparam int ABS_KEEP = 17;
    localparam int SQ_W     = 2 * ABS_KEEP;
    localparam int SUM_W    = SQ_W + 1;

    localparam logic [GATE_W-1:0] GATE_ONE = GATE_W'(65536);

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_APPEND = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    typedef struct packed {
        logic accept;
        logic append_write;
        logic scan_issue;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic scan_last;
        logic pipe_busy;
    } dp_status_t;

endpackage

// ===== src/gnlh_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module gnlh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/gnlh_datapath.sv =====
// Datapath: point table, entry count, scan address and the distance/gate pipeline.
// Depends on gnlh_pkg and gnlh_ram.
module gnlh_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  gnlh_pkg::ctrl_cmd_t            cmd,
    input  logic [gnlh_pkg::MODE_W-1:0]    in_mode,
    input  logic [gnlh_pkg::POS_W-1:0]     in_pos_x,
    input  logic [gnlh_pkg::POS_W-1:0]     in_pos_y,
    input  logic [gnlh_pkg::HEAD_W-1:0]    in_heading,
    input  logic [gnlh_pkg::WIDTH_W-1:0]   in_left_width,
    input  logic [gnlh_pkg::WIDTH_W-1:0]   in_right_width,
    output gnlh_pkg::dp_status_t           status,
    output logic [gnlh_pkg::STATUS_W-1:0]  out_status,
    output logic [gnlh_pkg::HEAD_W-1:0]    out_heading
);
    import gnlh_pkg::*;

    logic [MODE_W-1:0]    mode_reg;
    logic [POS_W-1:0]     qx_reg, qy_reg;
    logic [HEAD_W-1:0]    head_in_reg;
    logic [WIDTH_W-1:0]   wmax_reg;
    logic                 full_hit_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     scan_addr_reg, scan_addr_next;
    logic                 v1_reg, v2_reg, v3_reg;

    logic [ABS_KEEP-1:0]  a_ax_reg, a_ay_reg;
    logic                 a_far_reg;
    logic [HEAD_W-1:0]    a_head_reg, b_head_reg;
    logic [GATE_W-1:0]    a_gate_reg, b_gate_reg;
    logic [SQ_W-1:0]      b_sx_reg, b_sy_reg;
    logic                 b_far_reg;

    logic                 found_reg, found_next;
    logic [SUM_W-1:0]     best_reg;
    logic [HEAD_W-1:0]    best_head_reg;
    logic [STATUS_W-1:0]  out_status_reg, res_status;
    logic [HEAD_W-1:0]    out_heading_reg, res_heading;

    logic [2*WIDTH_W-1:0] wsq;
    logic [GATE_W-1:0]    gate_new;
    logic [IDX_W-1:0]     ram_addr;
    logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
    logic [POS_W-1:0]     rd_x, rd_y;
    logic [HEAD_W-1:0]    rd_head;
    logic [GATE_W-1:0]    rd_gate;
    logic [ABS_W-1:0]     dx, dy, ax, ay;
    logic [SUM_W-1:0]     sum;
    logic                 hit;

    // point table
    assign wsq       = wmax_reg * wmax_reg;
    assign gate_new  = GATE_ONE + GATE_W'(wsq);
    assign ram_addr  = cmd.append_write ? count_reg[IDX_W-1:0] : scan_addr_reg;
    assign ram_wdata = {gate_new, head_in_reg, qy_reg, qx_reg};

    gnlh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.append_write),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_x    = ram_rdata[POS_W-1:0];
    assign rd_y    = ram_rdata[2*POS_W-1:POS_W];
    assign rd_head = ram_rdata[2*POS_W+HEAD_W-1:2*POS_W];
    assign rd_gate = ram_rdata[ENTRY_W-1:2*POS_W+HEAD_W];

    // absolute differences, 33 bits
    assign dx = {qx_reg[POS_W-1], qx_reg} - {rd_x[POS_W-1], rd_x};
    assign dy = {qy_reg[POS_W-1], qy_reg} - {rd_y[POS_W-1], rd_y};
    assign ax = dx[ABS_W-1] ? (~dx + ABS_W'(1)) : dx;
    assign ay = dy[ABS_W-1] ? (~dy + ABS_W'(1)) : dy;

    // gate test; the gate is below 2^33, and once a hit is found a new hit must also beat the best sum
    assign sum = {1'b0, b_sx_reg} + {1'b0, b_sy_reg};
    assign hit = v3_reg && !b_far_reg && (sum < SUM_W'(b_gate_reg))
                 && (!found_reg || (sum < best_reg));

    always_comb begin
        count_next = count_reg;
        if (cmd.accept && (in_mode == MODE_CLEAR)) begin
            count_next = '0;
        end else if (cmd.append_write) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb begin
        scan_addr_next = scan_addr_reg;
        if (cmd.accept) begin
            scan_addr_next = '0;
        end else if (cmd.scan_issue) begin
            scan_addr_next = scan_addr_reg + IDX_W'(1);
        end
    end

    always_comb begin
        found_next = found_reg;
        if (cmd.accept) begin
            found_next = 1'b0;
        end else if (hit) begin
            found_next = 1'b1;
        end
    end

    always_comb begin
        res_status  = STATUS_OK;
        res_heading = '0;
        unique case (mode_reg)
            MODE_APPEND: res_status = full_hit_reg ? STATUS_FULL : STATUS_OK;
            MODE_QUERY: begin
                res_status  = found_reg ? STATUS_OK : STATUS_NO_MATCH;
                res_heading = found_reg ? best_head_reg : '0;
            end
            default: res_status = STATUS_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            scan_addr_reg <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            count_reg     <= count_next;
            scan_addr_reg <= scan_addr_next;
            v1_reg        <= cmd.scan_issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg     <= in_mode;
            qx_reg       <= in_pos_x;
            qy_reg       <= in_pos_y;
            head_in_reg  <= in_heading;
            wmax_reg     <= (in_left_width > in_right_width) ? in_left_width : in_right_width;
            full_hit_reg <= (count_reg == CNT_W'(MAX_ENTRIES));
        end
        a_ax_reg   <= ax[ABS_KEEP-1:0];
        a_ay_reg   <= ay[ABS_KEEP-1:0];
        a_far_reg  <= (|ax[ABS_W-1:ABS_KEEP]) || (|ay[ABS_W-1:ABS_KEEP]);
        a_head_reg <= rd_head;
        a_gate_reg <= rd_gate;
        b_sx_reg   <= a_ax_reg * a_ax_reg;
        b_sy_reg   <= a_ay_reg * a_ay_reg;
        b_far_reg  <= a_far_reg;
        b_head_reg <= a_head_reg;
        b_gate_reg <= a_gate_reg;
        if (hit) begin
            best_reg      <= sum;
            best_head_reg <= b_head_reg;
        end
        if (cmd.out_load) begin
            out_status_reg  <= res_status;
            out_heading_reg <= res_heading;
        end
    end

    assign status.full      = (count_reg == CNT_W'(MAX_ENTRIES));
    assign status.empty     = (count_reg == '0);
    assign status.scan_last = (CNT_W'(scan_addr_reg) == (count_reg - CNT_W'(1)));
    assign status.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign out_status       = out_status_reg;
    assign out_heading      = out_heading_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table size");

    a_write_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.append_write |-> (count_reg != CNT_W'(MAX_ENTRIES)))
        else $error("table write while full");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_issue |-> (CNT_W'(scan_addr_reg) < count_reg))
        else $error("scan read beyond stored entries");

endmodule

// ===== src/gnlh_ctrl.sv =====
// Controller state machine: sequences append, scan, drain and result handoff.
// Depends on gnlh_pkg.
module gnlh_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [gnlh_pkg::MODE_W-1:0] in_mode,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  gnlh_pkg::dp_status_t        status,
    output gnlh_pkg::ctrl_cmd_t         cmd
);
    import gnlh_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign s_tready   = (state_reg == ST_IDLE);
    assign out_free   = !out_valid_reg || m_tready;

    assign cmd.accept       = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.append_write = (state_reg == ST_APPEND);
    assign cmd.scan_issue   = (state_reg == ST_SCAN);
    assign cmd.out_load     = (state_reg == ST_DONE) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_mode)
                        MODE_APPEND: state_next = status.full ? ST_DONE : ST_APPEND;
                        MODE_QUERY:  state_next = status.empty ? ST_DONE : ST_SCAN;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_APPEND: state_next = ST_DONE;
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");

    a_load_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (state_reg == ST_IDLE) && m_tvalid)
        else $error("result handoff did not return to idle");

    a_done_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && $past(state_reg == ST_DRAIN)) |-> !status.pipe_busy)
        else $error("result formed before scan pipeline drained");

endmodule

// ===== src/gated_nearest_lane_heading.sv =====
// Top level of the gated nearest lane heading block.
// Depends on gnlh_pkg, gnlh_ctrl, gnlh_datapath (and through it gnlh_ram).
//
// One result per input transaction. An append writes one table entry unless the table
// is full, when it writes nothing and returns the full status. A query reads the point
// table through its single read port at one entry per cycle, up to 1024 entries in a
// full table, and then drains the registered read and the distance pipeline. Each
// result waits in an output register, so the next transaction is taken while it is held.
module gated_nearest_lane_heading (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata, from bit 0: pos_x[31:0], pos_y[31:0], heading_in[15:0],
    //                    left_width[15:0], right_width[15:0]
    input  logic [111:0] s_tdata,
    // tuser: mode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata, from bit 0: heading_out[15:0]
    output logic [15:0]  m_tdata,
    // tuser: status[1:0]
    output logic [1:0]   m_tuser
);
    import gnlh_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    gnlh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_mode  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (dp_status),
        .cmd      (cmd)
    );

    gnlh_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .in_mode        (s_tuser),
        .in_pos_x       (s_tdata[31:0]),
        .in_pos_y       (s_tdata[63:32]),
        .in_heading     (s_tdata[79:64]),
        .in_left_width  (s_tdata[95:80]),
        .in_right_width (s_tdata[111:96]),
        .status         (dp_status),
        .out_status     (m_tuser),
        .out_heading    (m_tdata)
    );

endmodule
